// ----- rtl/cas_pkg.sv -----
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants of the CIGAR alignment score unit.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int CH_W    = 8;
  localparam int ED_W    = 16;
  localparam int SCORE_W = 32;
  localparam int CFG_W   = 8;
  localparam int RUN_W   = 16;
  localparam int TOT_W   = 24;
  localparam int GAP_W   = 32;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Width of the unclamped score sum
  localparam int SUM_W   = 36;

  // Character codes
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;
  localparam logic [CH_W-1:0] CH_M    = 8'h4D;
  localparam logic [CH_W-1:0] CH_I    = 8'h49;
  localparam logic [CH_W-1:0] CH_D    = 8'h44;

  localparam int RADIX = 10;

  // Register indexes
  localparam logic [1:0] REG_MATCH_SCORE      = 2'd0;
  localparam logic [1:0] REG_MISMATCH_PENALTY = 2'd1;
  localparam logic [1:0] REG_GAP_OPEN         = 2'd2;
  localparam logic [1:0] REG_GAP_EXTEND       = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_MATCH_SCORE      = 8'd1;
  localparam logic [CFG_W-1:0] RST_MISMATCH_PENALTY = 8'd2;
  localparam logic [CFG_W-1:0] RST_GAP_OPEN         = 8'd3;
  localparam logic [CFG_W-1:0] RST_GAP_EXTEND       = 8'd1;

  typedef struct packed {
    logic [CFG_W-1:0] match_score;
    logic [CFG_W-1:0] mismatch_penalty;
    logic [CFG_W-1:0] gap_open;
    logic [CFG_W-1:0] gap_extend;
  } cfg_t;

  // Totals of one finished string, handed to the score pipeline
  typedef struct packed {
    logic [TOT_W-1:0] match_total;
    logic [TOT_W-1:0] indel_total;
    logic [GAP_W-1:0] gap_penalty;
    logic [ED_W-1:0]  edit_distance;
  } score_ops_t;

endpackage

// ----- rtl/cas_in_if.sv -----
// ----------------------------------------------------------------------------
// cas_in_if
// Character stream channel: valid/ready with one CIGAR character per transfer.
// ----------------------------------------------------------------------------
interface cas_in_if;
  import cas_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   ch;
  logic              last;
  logic [ED_W-1:0]   edit_distance;

  modport source (output valid, output ch, output last, output edit_distance,
                  input ready);
  modport sink (input valid, input ch, input last, input edit_distance,
                output ready);
endinterface

// ----- rtl/cas_out_if.sv -----
// ----------------------------------------------------------------------------
// cas_out_if
// Score channel: valid/ready with one signed score per transfer.
// ----------------------------------------------------------------------------
interface cas_out_if;
  import cas_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;

  modport source (output valid, output score, input ready);
  modport sink (input valid, input score, output ready);
endinterface

// ----- rtl/cas_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cas_cfg_regs
// APB-style register file holding the four scoring weights.
// ----------------------------------------------------------------------------
module cas_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cas_pkg::ADDR_W-1:0]  paddr,
  input  logic [cas_pkg::DATA_W-1:0]  pwdata,
  output logic [cas_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cas_pkg::cfg_t               cfg
);
  import cas_pkg::*;

  logic [1:0] index;
  logic       wr_en;

  assign index  = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_score      <= RST_MATCH_SCORE;
      cfg.mismatch_penalty <= RST_MISMATCH_PENALTY;
      cfg.gap_open         <= RST_GAP_OPEN;
      cfg.gap_extend       <= RST_GAP_EXTEND;
    end else if (wr_en) begin
      unique case (index)
        REG_MATCH_SCORE:      cfg.match_score      <= pwdata[CFG_W-1:0];
        REG_MISMATCH_PENALTY: cfg.mismatch_penalty <= pwdata[CFG_W-1:0];
        REG_GAP_OPEN:         cfg.gap_open         <= pwdata[CFG_W-1:0];
        REG_GAP_EXTEND:       cfg.gap_extend       <= pwdata[CFG_W-1:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_MATCH_SCORE:      prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.match_score};
      REG_MISMATCH_PENALTY: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.mismatch_penalty};
      REG_GAP_OPEN:         prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.gap_open};
      REG_GAP_EXTEND:       prdata = {{(DATA_W-CFG_W){1'b0}}, cfg.gap_extend};
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cas_parser.sv -----
// ----------------------------------------------------------------------------
// cas_parser
// Per-character state update: run length, totals and gap penalty.
// ----------------------------------------------------------------------------
module cas_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [cas_pkg::CH_W-1:0]  ch,
  input  logic                      last,
  input  logic [cas_pkg::ED_W-1:0]  edit_distance,
  input  cas_pkg::cfg_t             cfg,
  output logic                      ops_valid,
  output cas_pkg::score_ops_t       ops
);
  import cas_pkg::*;

  typedef enum logic [1:0] {
    PH_START,
    PH_NUM,
    PH_STOP
  } phase_t;

  phase_t           phase, phase_next;
  logic [RUN_W-1:0] run_length, run_length_next;
  logic [TOT_W-1:0] match_total, match_total_next;
  logic [TOT_W-1:0] indel_total, indel_total_next;
  logic [GAP_W-1:0] gap_penalty, gap_penalty_next;

  logic             digit;
  logic [3:0]       dval;
  logic [RUN_W+3:0] run_x10;
  logic [RUN_W+3:0] run_acc;
  logic [TOT_W:0]   match_sum;
  logic [TOT_W:0]   indel_sum;
  logic [TOT_W-1:0] ext_prod;
  logic [TOT_W:0]   gap_inc;
  logic [GAP_W:0]   gap_sum;

  always_comb begin
    digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dval      = 4'(ch - CH_ZERO);
    run_x10   = {4'b0, run_length} * (RUN_W+4)'(RADIX);
    run_acc   = run_x10 + {{RUN_W{1'b0}}, dval};
    match_sum = {1'b0, match_total} + {{(TOT_W-RUN_W+1){1'b0}}, run_length};
    indel_sum = {1'b0, indel_total} + {{(TOT_W-RUN_W+1){1'b0}}, run_length};
    ext_prod  = {{(TOT_W-CFG_W){1'b0}}, cfg.gap_extend} *
                {{(TOT_W-RUN_W){1'b0}}, run_length};
    gap_inc   = {1'b0, ext_prod} + {{(TOT_W-CFG_W+1){1'b0}}, cfg.gap_open};
    gap_sum   = {1'b0, gap_penalty} + {{(GAP_W-TOT_W){1'b0}}, gap_inc};

    phase_next       = phase;
    run_length_next  = run_length;
    match_total_next = match_total;
    indel_total_next = indel_total;
    gap_penalty_next = gap_penalty;

    unique case (phase)
      PH_START: begin
        if (digit) begin
          run_length_next = {{(RUN_W-4){1'b0}}, dval};
          phase_next      = PH_NUM;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_NUM: begin
        if (digit) begin
          run_length_next = (run_acc > {4'b0, {RUN_W{1'b1}}}) ? {RUN_W{1'b1}}
                                                             : run_acc[RUN_W-1:0];
        end else begin
          if (ch == CH_M) begin
            match_total_next = match_sum[TOT_W] ? {TOT_W{1'b1}} : match_sum[TOT_W-1:0];
          end else if (ch == CH_I || ch == CH_D) begin
            indel_total_next = indel_sum[TOT_W] ? {TOT_W{1'b1}} : indel_sum[TOT_W-1:0];
            gap_penalty_next = gap_sum[GAP_W] ? {GAP_W{1'b1}} : gap_sum[GAP_W-1:0];
          end
          run_length_next = '0;
          phase_next      = PH_START;
        end
      end
      default: ;
    endcase
  end

  // Totals after this character, as the score sees them
  assign ops_valid         = accept && last;
  assign ops.match_total   = match_total_next;
  assign ops.indel_total   = indel_total_next;
  assign ops.gap_penalty   = gap_penalty_next;
  assign ops.edit_distance = edit_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      run_length  <= '0;
      match_total <= '0;
      indel_total <= '0;
      gap_penalty <= '0;
    end else if (accept) begin
      if (last) begin
        phase       <= PH_START;
        run_length  <= '0;
        match_total <= '0;
        indel_total <= '0;
        gap_penalty <= '0;
      end else begin
        phase       <= phase_next;
        run_length  <= run_length_next;
        match_total <= match_total_next;
        indel_total <= indel_total_next;
        gap_penalty <= gap_penalty_next;
      end
    end
  end

endmodule

// ----- rtl/cas_score.sv -----
// ----------------------------------------------------------------------------
// cas_score
// Three-stage elastic pipeline: capture totals, multiply, sum and clamp.
// ----------------------------------------------------------------------------
module cas_score (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ops_valid,
  input  cas_pkg::score_ops_t   ops,
  input  cas_pkg::cfg_t         cfg,
  output logic                  ops_ready,
  cas_out_if.source             score_out
);
  import cas_pkg::*;

  localparam int DIFF_W = TOT_W + 1;
  localparam int WT_W   = CFG_W + 2;
  localparam int MIS_W  = DIFF_W + WT_W;

  // Stage 1: captured totals
  logic       v1;
  score_ops_t ops1;

  // Stage 2: products
  logic                     v2;
  logic [SCORE_W-1:0]       p_match;
  logic signed [MIS_W-1:0]  p_mis;
  logic [GAP_W-1:0]         gap2;

  // Stage 3: output register
  logic                      v3;
  logic signed [SCORE_W-1:0] score;

  logic ready1, ready2, ready3;

  logic signed [DIFF_W-1:0] diff;
  logic signed [WT_W-1:0]   weight;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  score_max;
  logic signed [SUM_W-1:0]  score_min;

  assign ready3    = !v3 || score_out.ready;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign ops_ready = ready1;

  assign diff   = $signed({{(DIFF_W-ED_W){1'b0}}, ops1.edit_distance}) -
                  $signed({1'b0, ops1.indel_total});
  assign weight = $signed({2'b0, cfg.match_score}) + $signed({2'b0, cfg.mismatch_penalty});

  assign score_max = $signed({{(SUM_W-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}});
  assign score_min = $signed({{(SUM_W-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}});
  assign sum = $signed({{(SUM_W-SCORE_W){1'b0}}, p_match})
             - {{(SUM_W-MIS_W){p_mis[MIS_W-1]}}, p_mis}
             - $signed({{(SUM_W-GAP_W){1'b0}}, gap2});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= ops_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && ops_valid) ops1 <= ops;
    if (ready2 && v1) begin
      p_match <= {{(SCORE_W-TOT_W){1'b0}}, ops1.match_total} *
                 {{(SCORE_W-CFG_W){1'b0}}, cfg.match_score};
      p_mis   <= MIS_W'(diff) * MIS_W'(weight);
      gap2    <= ops1.gap_penalty;
    end
    if (ready3 && v2) begin
      priority if (sum > score_max) score <= score_max[SCORE_W-1:0];
      else if (sum < score_min)     score <= score_min[SCORE_W-1:0];
      else                          score <= sum[SCORE_W-1:0];
    end
  end

  assign score_out.valid = v3;
  assign score_out.score = score;

endmodule

// ----- rtl/cigar_alignment_score_unit.sv -----
// ----------------------------------------------------------------------------
// cigar_alignment_score_unit
// Streaming affine-gap alignment score of a CIGAR string.
// ----------------------------------------------------------------------------
//
//   channel    direction  carries                          protocol
//   item_in    in         ch, last, edit_distance          valid/ready
//   score_out  out        score (signed 32 bits)           valid/ready
//   cfg        in/out     match_score .. gap_extend        APB-style, 4 regs
//
// One character is transferred per cycle while item_in.ready is high; the
// totals after a character flagged last are captured at its transfer and run
// through three registers (capture, multiply, sum and clamp) before its score
// is offered. Elastic pipeline: a stalled score_out holds item_in back only
// once all three stages are full. Synchronous reset clears the parser and the
// pipeline and sets the weights to their defaults; there is no clearing pass.
//
module cigar_alignment_score_unit (
  input  logic                        clk,
  input  logic                        rst,
  cas_in_if.sink                      item_in,
  cas_out_if.source                   score_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cas_pkg::ADDR_W-1:0]  paddr,
  input  logic [cas_pkg::DATA_W-1:0]  pwdata,
  output logic [cas_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import cas_pkg::*;

  cfg_t       cfg;
  score_ops_t ops;
  logic       ops_valid;
  logic       ops_ready;
  logic       accept;

  // Hold every character while the score pipeline cannot take another result
  assign item_in.ready = ops_ready;
  assign accept        = item_in.valid && ops_ready;

  cas_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the run length and totals on each transfer; clear after last
  cas_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .ch            (item_in.ch),
    .last          (item_in.last),
    .edit_distance (item_in.edit_distance),
    .cfg           (cfg),
    .ops_valid     (ops_valid),
    .ops           (ops)
  );

  // Turn the final totals into a clamped score
  cas_score u_score (
    .clk       (clk),
    .rst       (rst),
    .ops_valid (ops_valid),
    .ops       (ops),
    .cfg       (cfg),
    .ops_ready (ops_ready),
    .score_out (score_out)
  );

endmodule

// ----- test/cigar_alignment_score_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_alignment_score_unit_test
// Self-checking bench for the CIGAR alignment score unit. CIGAR strings are
// streamed one character per transfer with random gaps on both channels.
// A scoreboard model parses the same characters and predicts each score,
// which is compared against the block's output in order. The weights are
// reprogrammed over APB between idle phases, the extremes included.
// ----------------------------------------------------------------------------
module cigar_alignment_score_unit_test;
  import cas_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // Pipeline depth is three stages after the parser; SETTLE adds spare wait time
  localparam int SETTLE      = 8;
  // Enough saturated indel runs to push the score past its upper clamp
  localparam int HEAVY_RUNS  = 70;
  localparam int PHASE_ITEMS = 110;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;
  localparam logic [GAP_W-1:0] GAP_MAX = '1;
  localparam longint SCORE_HI = 64'sd2147483647;
  localparam longint SCORE_LO = -64'sd2147483648;
  // Operation letters that the block consumes but does not score
  localparam byte unsigned IGNORED_OPS [6] = '{"S", "H", "N", "P", "X", "="};

  typedef enum logic [1:0] {AT_START, IN_NUMBER, STOPPED} parse_phase_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic [ED_W-1:0] ed;
  } cigar_item_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  cas_in_if  item_bus ();
  cas_out_if score_bus ();

  cigar_alignment_score_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_bus),
    .score_out(score_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Characters waiting to be offered, and scores waiting to come out
  cigar_item_t pending_items [$];
  logic signed [SCORE_W-1:0] expected_scores [$];

  // Scoreboard copy of the parser state and of the weight registers
  cfg_t             weights;
  parse_phase_t     parse_phase;
  logic [RUN_W-1:0] run_len;
  logic [TOT_W-1:0] match_sum;
  logic [TOT_W-1:0] indel_sum;
  logic [GAP_W-1:0] gap_sum;

  int  fault_count;
  int  cycle_count;
  logic item_taken;

  // Gap counters of the two channels; calm counters give stretches with no idling
  int feed_gap, feed_calm, drain_gap, drain_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_digit(input logic [CH_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic longint sat(input longint v, input longint lim);
    return v > lim ? lim : v;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Edit distance: random on inner characters, weighted towards the edges on last
  function automatic logic [ED_W-1:0] item_ed(input bit lst);
    int r;
    if (!lst) return ED_W'($urandom_range(0, 65535));
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return ED_W'($urandom_range(0, 65535));
    return ED_W'($urandom_range(0, 200));
  endfunction

  // Any non-digit: mostly scored operations, some ignored ones, some raw bytes
  function automatic logic [CH_W-1:0] pick_op();
    int r;
    logic [CH_W-1:0] b;
    r = $urandom_range(0, 99);
    if (r < 40) return CH_M;
    if (r < 60) return CH_I;
    if (r < 80) return CH_D;
    if (r < 95) return IGNORED_OPS[$urandom_range(0, 5)];
    b = CH_W'($urandom_range(0, 255));
    if (is_digit(b)) b = b ^ 8'h80;
    return b;
  endfunction

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 72) return $urandom_range(1, 99);
    if (r < 92) return $urandom_range(100, 9999);
    return $urandom_range(10000, 99999);
  endfunction

  function automatic logic [CFG_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return CFG_W'($urandom_range(0, 255));
  endfunction

  // Advance the scoreboard parser by one accepted character
  task automatic parse_char(input logic [CH_W-1:0] c, input logic lst,
                            input logic [ED_W-1:0] ed);
    longint r;
    longint s;
    case (parse_phase)
      AT_START: begin
        if (is_digit(c)) begin
          run_len     = RUN_W'(c - CH_ZERO);
          parse_phase = IN_NUMBER;
        end else begin
          parse_phase = STOPPED;
        end
      end
      IN_NUMBER: begin
        if (is_digit(c)) begin
          r = longint'(run_len) * RADIX + (longint'(c) - longint'(CH_ZERO));
          run_len = RUN_W'(sat(r, longint'(RUN_MAX)));
        end else begin
          if (c == CH_M) begin
            match_sum = TOT_W'(sat(longint'(match_sum) + longint'(run_len),
                                   longint'(TOT_MAX)));
          end else if (c == CH_I || c == CH_D) begin
            indel_sum = TOT_W'(sat(longint'(indel_sum) + longint'(run_len),
                                   longint'(TOT_MAX)));
            gap_sum   = GAP_W'(sat(longint'(gap_sum) + longint'(weights.gap_open)
                                   + longint'(weights.gap_extend) * longint'(run_len),
                                   longint'(GAP_MAX)));
          end
          run_len     = '0;
          parse_phase = AT_START;
        end
      end
      default: ;
    endcase
    if (lst) begin
      s = longint'(match_sum) * longint'(weights.match_score)
          - (longint'(ed) - longint'(indel_sum))
            * (longint'(weights.match_score) + longint'(weights.mismatch_penalty))
          - longint'(gap_sum);
      if (s > SCORE_HI) s = SCORE_HI;
      if (s < SCORE_LO) s = SCORE_LO;
      expected_scores.insert(expected_scores.size(), s[SCORE_W-1:0]);
      run_len     = '0;
      match_sum   = '0;
      indel_sum   = '0;
      gap_sum     = '0;
      parse_phase = AT_START;
    end
  endtask

  task automatic push_char(input logic [CH_W-1:0] c, input logic lst,
                           input logic [ED_W-1:0] ed);
    cigar_item_t it;
    it.ch   = c;
    it.last = lst;
    it.ed   = ed;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Queue a literal string, last flag on its final character
  task automatic push_text(input string s, input logic [ED_W-1:0] ed);
    int k;
    for (k = 0; k < s.len(); k++) begin
      push_char(s[k], k == s.len() - 1, (k == s.len() - 1) ? ed : item_ed(1'b0));
    end
  endtask

  task automatic push_number(input int unsigned value, input bit leading_zero,
                             input bit end_here);
    byte unsigned digits [$];
    int unsigned v;
    int k;
    bit lst;
    v = value;
    do begin
      digits.push_front(8'(CH_ZERO + v % RADIX));
      v = v / RADIX;
    end while (v != 0);
    if (leading_zero) digits.push_front(CH_ZERO);
    for (k = 0; k < digits.size(); k++) begin
      lst = end_here && (k == digits.size() - 1);
      push_char(digits[k], lst, item_ed(lst));
    end
  endtask

  // One random string: mostly well formed, the rest broken or plain noise
  task automatic queue_string();
    int kind;
    int n_ops;
    int n_tail;
    int k;
    bit lst;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      n_ops = $urandom_range(1, 8);
      for (k = 0; k < n_ops; k++) begin
        push_number(pick_len(), $urandom_range(0, 9) == 0, 1'b0);
        push_char(pick_op(), k == n_ops - 1, item_ed(k == n_ops - 1));
      end
    end else if (kind == 7) begin
      // drop the final run: string ends inside a number
      n_ops = $urandom_range(0, 4);
      for (k = 0; k < n_ops; k++) begin
        push_number(pick_len(), 1'b0, 1'b0);
        push_char(pick_op(), 1'b0, item_ed(1'b0));
      end
      push_number(pick_len(), 1'b0, 1'b1);
    end else if (kind == 8) begin
      // non-digit where a number should start, then ignored trailing bytes
      n_ops = $urandom_range(0, 3);
      for (k = 0; k < n_ops; k++) begin
        push_number(pick_len(), 1'b0, 1'b0);
        push_char(pick_op(), 1'b0, item_ed(1'b0));
      end
      n_tail = $urandom_range(0, 4);
      push_char(pick_op(), n_tail == 0, item_ed(n_tail == 0));
      for (k = 0; k < n_tail; k++) begin
        lst = (k == n_tail - 1);
        push_char(CH_W'($urandom_range(0, 255)), lst, item_ed(lst));
      end
    end else begin
      n_tail = $urandom_range(1, 6);
      for (k = 0; k < n_tail; k++) begin
        lst = (k == n_tail - 1);
        push_char(CH_W'($urandom_range(0, 255)), lst, item_ed(lst));
      end
    end
  endtask

  // Long string of saturating runs to drive the totals and the score towards their limits
  task automatic queue_heavy(input bit gaps_only);
    int k;
    bit lst;
    logic [CH_W-1:0] op;
    for (k = 0; k < HEAVY_RUNS; k++) begin
      push_number($urandom_range(70000, 99999), 1'b0, 1'b0);
      op  = gaps_only ? ($urandom_range(0, 1) ? CH_I : CH_D) : CH_M;
      lst = (k == HEAVY_RUNS - 1);
      push_char(op, lst, item_ed(lst));
    end
  endtask

  // APB write: setup cycle, access cycle, register taken at the following edge
  task automatic write_weight(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MATCH_SCORE:      weights.match_score      = val;
      REG_MISMATCH_PENALTY: weights.mismatch_penalty = val;
      REG_GAP_OPEN:         weights.gap_open         = val;
      default:              weights.gap_extend       = val;
    endcase
  endtask

  task automatic set_weights(input logic [CFG_W-1:0] ms, input logic [CFG_W-1:0] mp,
                             input logic [CFG_W-1:0] go, input logic [CFG_W-1:0] ge);
    write_weight(REG_MATCH_SCORE, ms);
    write_weight(REG_MISMATCH_PENALTY, mp);
    write_weight(REG_GAP_OPEN, go);
    write_weight(REG_GAP_EXTEND, ge);
  endtask

  // Hold the sender until every queued character is gone and every score is in
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_bus.valid || expected_scores.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Driver: offer the next character at the falling edge, hold it until transfer
  always @(negedge clk) begin : feed_side
    cigar_item_t it;
    int g;
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!(item_bus.valid && !item_taken)) begin
      g = feed_gap;
      if (item_bus.valid) begin
        // a transfer just happened: pick the gap before the next character
        if (feed_calm > 0) begin
          feed_calm--;
          g = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) feed_calm = $urandom_range(30, 120);
          g = pick_gap();
        end
      end
      if (g > 0) begin
        item_bus.valid <= 1'b0;
        feed_gap = g - 1;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        item_bus.valid         <= 1'b1;
        item_bus.ch            <= it.ch;
        item_bus.last          <= it.last;
        item_bus.edit_distance <= it.ed;
        feed_gap = 0;
      end else begin
        item_bus.valid <= 1'b0;
        feed_gap = 0;
      end
    end
  end

  // Receiver: stall score_out at random, with calm stretches
  always @(negedge clk) begin : drain_side
    int g;
    if (drain_gap > 0) begin
      drain_gap--;
      score_bus.ready <= 1'b0;
    end else begin
      if (drain_calm > 0) begin
        drain_calm--;
        g = 0;
      end else begin
        if ($urandom_range(0, 49) == 0) drain_calm = $urandom_range(30, 120);
        g = pick_gap();
      end
      score_bus.ready <= (g == 0);
      drain_gap = (g > 0) ? g - 1 : 0;
    end
  end

  // Monitor: check each score transfer, then feed accepted characters to the model
  always @(posedge clk) begin : check_side
    logic signed [SCORE_W-1:0] want;
    if (!rst) begin
      if (score_bus.valid && score_bus.ready) begin
        if (expected_scores.size() == 0) begin
          if (fault_count < 10) $display("unexpected score %0d", score_bus.score);
          fault_count++;
        end else begin
          want = expected_scores.pop_front();
          if (score_bus.score !== want) begin
            if (fault_count < 10)
              $display("score mismatch: expected %0d, got %0d", want, score_bus.score);
            fault_count++;
          end
        end
      end
      if (item_bus.valid && item_bus.ready)
        parse_char(item_bus.ch, item_bus.last, item_bus.edit_distance);
    end
    item_taken <= !rst && item_bus.valid && item_bus.ready;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    int start_size;
    int added;
    // drive every input to a known value from time zero
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    item_bus.valid         = 1'b0;
    item_bus.ch            = '0;
    item_bus.last          = 1'b0;
    item_bus.edit_distance = '0;
    score_bus.ready        = 1'b0;
    item_taken             = 1'b0;
    fault_count            = 0;
    cycle_count            = 0;
    feed_gap               = 0;
    feed_calm              = 0;
    drain_gap              = 0;
    drain_calm             = 0;
    weights.match_score      = RST_MATCH_SCORE;
    weights.mismatch_penalty = RST_MISMATCH_PENALTY;
    weights.gap_open         = RST_GAP_OPEN;
    weights.gap_extend       = RST_GAP_EXTEND;
    parse_phase = AT_START;
    run_len     = '0;
    match_sum   = '0;
    indel_sum   = '0;
    gap_sum     = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the reset weights
    push_text("12M5I3D", '0);         // all three scored operations, digit after op
    push_text("4S", '1);              // ignored operation, widest edit distance
    push_text("A3M", 16'd7);          // stop at number start, rest ignored
    push_text("2M7", 16'd1);          // pending run dropped at end of string
    push_char(8'h00, 1'b1, 16'h00FF); // lone non-digit, lowest byte
    push_char(8'hFF, 1'b1, 16'hFF00); // lone non-digit, highest byte
    push_text("0I", '0);              // zero-length gap still pays gap_open
    push_text("70000D", 16'd3);       // run length saturates
    wait_drained();

    // Random phases, each on its own weights
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        1:       set_weights('0, '0, '0, '0);
        2:       set_weights('1, '1, '1, '1);
        default: set_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight());
      endcase
      start_size = 0;
      added      = 0;
      while (added < PHASE_ITEMS) begin
        start_size = pending_items.size();
        queue_string();
        added += pending_items.size() - start_size;
      end
      wait_drained();
    end

    // Saturate every run length, pile up indels with free gaps and clamp the score high
    set_weights('1, '1, '0, '0);
    queue_heavy(1'b1);
    queue_string();
    wait_drained();

    if (fault_count == 0 && expected_scores.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
